// ----- rtl/tpcl_pkg.sv -----
`default_nettype none

package tpcl_pkg;

  localparam int PROTO_W  = 24;
  localparam int SAMPLE_W = 8;
  localparam int FRAC_W   = 16;
  localparam int RATE_W   = 16;
  localparam int IDX_W    = 4;
  localparam int SQ_W     = 2 * PROTO_W;
  localparam int DIST_W   = 52;
  localparam int MAG_W    = PROTO_W + RATE_W;
  localparam int COUNT_W  = 5;

  localparam logic [RATE_W-1:0] WIN_RATE_RST  = 16'd6554;
  localparam logic [RATE_W-1:0] LOSE_RATE_RST = 16'd655;

  typedef enum logic [1:0] {
    OP_TRAIN  = 2'd0,
    OP_LOAD_A = 2'd1,
    OP_LOAD_B = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic {
    KIND_TRAIN = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_WIN_RATE  = 1'b0,
    CFG_LOSE_RATE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e                 opcode;
    logic [IDX_W-1:0]    index;
    logic [SAMPLE_W-1:0] sample_value;
    logic [PROTO_W-1:0]  proto_value;
    logic                last;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic               winner;
    logic [COUNT_W-1:0] count_a_greater;
    logic [PROTO_W-1:0] read_a;
    logic [PROTO_W-1:0] read_b;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic dispatch;
    logic sel_cnt;
    logic square;
    logic accum;
    logic win;
    logic upd_mul;
    logic upd_wr;
    logic emit_rd;
    logic emit_tr;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic last;
    logic cnt_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/tpcl_if.sv -----
`default_nettype none

interface tpcl_in_if;
  import tpcl_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpcl_out_if;
  import tpcl_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tpcl_ctrl.sv -----
`default_nettype none

module tpcl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tpcl_pkg::status_t status_i,
  output tpcl_pkg::cmd_t    cmd_o
);
  import tpcl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_SQUARE   = 10'b00_0000_0100,
    S_ACCUM    = 10'b00_0000_1000,
    S_WIN      = 10'b00_0001_0000,
    S_UPD_RD   = 10'b00_0010_0000,
    S_UPD_MUL  = 10'b00_0100_0000,
    S_UPD_WR   = 10'b00_1000_0000,
    S_EMIT_RD  = 10'b01_0000_0000,
    S_EMIT_TR  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        unique case (status_i.op) inside
          OP_TRAIN:             state_d = S_SQUARE;
          OP_LOAD_A, OP_LOAD_B: state_d = S_IDLE;
          OP_READ:              state_d = S_EMIT_RD;
          default:              state_d = S_IDLE;
        endcase
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_ACCUM;
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.last ? S_WIN : S_IDLE;
      end
      S_WIN: begin
        cmd_o.win = 1'b1;
        state_d   = S_UPD_RD;
      end
      S_UPD_RD: begin
        cmd_o.sel_cnt = 1'b1;
        state_d       = S_UPD_MUL;
      end
      S_UPD_MUL: begin
        cmd_o.sel_cnt = 1'b1;
        cmd_o.upd_mul = 1'b1;
        state_d       = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd_o.sel_cnt = 1'b1;
        cmd_o.upd_wr  = 1'b1;
        state_d       = status_i.cnt_last ? S_EMIT_TR : S_UPD_RD;
      end
      S_EMIT_RD: begin
        if (status_i.out_free) begin
          cmd_o.emit_rd = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_EMIT_TR: begin
        if (status_i.out_free) begin
          cmd_o.emit_tr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tpcl_dpath.sv -----
`default_nettype none

module tpcl_dpath #(
  parameter int DIMENSIONS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  tpcl_pkg::cfg_reg_e            cfg_index_i,
  input  logic [tpcl_pkg::RATE_W-1:0]   cfg_wdata_i,
  input  tpcl_pkg::in_item_t            in_data_i,
  input  tpcl_pkg::cmd_t                cmd_i,
  output tpcl_pkg::status_t             status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output tpcl_pkg::out_item_t           out_data_o
);
  import tpcl_pkg::*;

  localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  function automatic logic [PROTO_W-1:0] abs_diff(input logic [PROTO_W-1:0] x,
                                                  input logic [PROTO_W-1:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] acc,
                                                input logic [SQ_W-1:0]   sq);
    logic [DIST_W:0] sum;
    sum = {1'b0, acc} + (DIST_W+1)'(sq);
    return sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
  endfunction

  // up: move toward a larger sample, floor; otherwise step rounds up (floor of the result)
  function automatic logic [PROTO_W-1:0] move(input logic [PROTO_W-1:0] p,
                                             input logic               up,
                                             input logic [MAG_W-1:0]   mag);
    logic [PROTO_W-1:0] step;
    step = mag[MAG_W-1:RATE_W] + PROTO_W'(!up && (|mag[RATE_W-1:0]));
    return up ? (p + step) : (p - step);
  endfunction

  // configuration
  logic [RATE_W-1:0] win_rate_q, lose_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_rate_q  <= WIN_RATE_RST;
      lose_rate_q <= LOSE_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIN_RATE:  win_rate_q  <= cfg_wdata_i;
        CFG_LOSE_RATE: lose_rate_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // captured item
  op_e                 op_q;
  logic [AW-1:0]       addr_q;
  logic                ok_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [PROTO_W-1:0]  pval_q;
  logic                last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= in_data_i.opcode;
      addr_q   <= AW'(in_data_i.index);
      ok_q     <= int'(in_data_i.index) < DIMENSIONS;
      sample_q <= in_data_i.sample_value;
      pval_q   <= in_data_i.proto_value;
      last_q   <= in_data_i.last;
    end
  end

  // prototype and sample memories
  logic [PROTO_W-1:0]  mem_a [DIMENSIONS];
  logic [PROTO_W-1:0]  mem_b [DIMENSIONS];
  logic [SAMPLE_W-1:0] mem_s [DIMENSIONS];
  logic [DIMENSIONS-1:0] val_a_q, val_b_q;

  logic [AW-1:0]       cnt_q;
  logic [AW-1:0]       raddr, waddr;
  logic                we_a, we_b, we_s;
  logic [PROTO_W-1:0]  wdata_a, wdata_b;
  logic [PROTO_W-1:0]  new_a, new_b;
  logic [PROTO_W-1:0]  rd_a_q, rd_b_q;
  logic [SAMPLE_W-1:0] rd_s_q;
  logic                rd_va_q, rd_vb_q;
  logic [PROTO_W-1:0]  pa, pb;

  assign raddr   = cmd_i.sel_cnt ? cnt_q : addr_q;
  assign waddr   = cmd_i.upd_wr ? cnt_q : addr_q;
  assign we_a    = cmd_i.upd_wr || (cmd_i.dispatch && ok_q && op_q == OP_LOAD_A);
  assign we_b    = cmd_i.upd_wr || (cmd_i.dispatch && ok_q && op_q == OP_LOAD_B);
  assign we_s    = cmd_i.dispatch && ok_q && op_q == OP_TRAIN;
  assign wdata_a = cmd_i.upd_wr ? new_a : pval_q;
  assign wdata_b = cmd_i.upd_wr ? new_b : pval_q;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[waddr] <= wdata_a;
    end
    if (we_b) begin
      mem_b[waddr] <= wdata_b;
    end
    if (we_s) begin
      mem_s[addr_q] <= sample_q;
    end
    rd_a_q <= mem_a[raddr];
    rd_b_q <= mem_b[raddr];
    rd_s_q <= mem_s[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_a_q <= '0;
      val_b_q <= '0;
      rd_va_q <= 1'b0;
      rd_vb_q <= 1'b0;
    end else begin
      if (we_a) begin
        val_a_q[waddr] <= 1'b1;
      end
      if (we_b) begin
        val_b_q[waddr] <= 1'b1;
      end
      rd_va_q <= val_a_q[raddr];
      rd_vb_q <= val_b_q[raddr];
    end
  end

  assign pa = rd_va_q ? rd_a_q : '0;
  assign pb = rd_vb_q ? rd_b_q : '0;

  // distance accumulation
  logic [PROTO_W-1:0] s_item, s_mem;
  logic [PROTO_W-1:0] dsq_a, dsq_b;
  logic [SQ_W-1:0]    sq_a, sq_b, sq_a_q, sq_b_q;
  logic [DIST_W-1:0]  dist_a_q, dist_b_q;
  logic               win_q;

  assign s_item = PROTO_W'({sample_q, {FRAC_W{1'b0}}});
  assign s_mem  = PROTO_W'({rd_s_q, {FRAC_W{1'b0}}});
  assign dsq_a  = abs_diff(pa, s_item);
  assign dsq_b  = abs_diff(pb, s_item);
  assign sq_a   = SQ_W'(dsq_a) * SQ_W'(dsq_a);
  assign sq_b   = SQ_W'(dsq_b) * SQ_W'(dsq_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sq_a_q <= sq_a;
      sq_b_q <= sq_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_a_q <= '0;
      dist_b_q <= '0;
      win_q    <= 1'b0;
    end else if (cmd_i.win) begin
      win_q    <= (dist_a_q < dist_b_q) ? 1'b0 : 1'b1;
      dist_a_q <= '0;
      dist_b_q <= '0;
    end else if (cmd_i.accum && ok_q) begin
      dist_a_q <= sat_add(dist_a_q, sq_a_q);
      dist_b_q <= sat_add(dist_b_q, sq_b_q);
    end
  end

  // prototype update, one component per pass
  logic [RATE_W-1:0]  rate_a, rate_b;
  logic [PROTO_W-1:0] du_a, du_b;
  logic [MAG_W-1:0]   mag_a, mag_b, mag_a_q, mag_b_q;
  logic [PROTO_W-1:0] p_a_q, p_b_q;
  logic               up_a_q, up_b_q;
  logic [COUNT_W-1:0] count_q;

  assign rate_a = win_q ? lose_rate_q : win_rate_q;
  assign rate_b = win_q ? win_rate_q : lose_rate_q;
  assign du_a   = abs_diff(pa, s_mem);
  assign du_b   = abs_diff(pb, s_mem);
  assign mag_a  = MAG_W'(du_a) * MAG_W'(rate_a);
  assign mag_b  = MAG_W'(du_b) * MAG_W'(rate_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_mul) begin
      p_a_q   <= pa;
      p_b_q   <= pb;
      up_a_q  <= s_mem >= pa;
      up_b_q  <= s_mem >= pb;
      mag_a_q <= mag_a;
      mag_b_q <= mag_b;
    end
  end

  assign new_a = move(p_a_q, up_a_q, mag_a_q);
  assign new_b = move(p_b_q, up_b_q, mag_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.win) begin
      cnt_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.upd_wr) begin
      cnt_q <= cnt_q + 1'b1;
      if (new_a > new_b && count_q != {COUNT_W{1'b1}}) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // result register
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_rd || cmd_i.emit_tr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rd) begin
      out_data_q.kind            <= KIND_READ;
      out_data_q.winner          <= 1'b0;
      out_data_q.count_a_greater <= '0;
      out_data_q.read_a          <= ok_q ? pa : '0;
      out_data_q.read_b          <= ok_q ? pb : '0;
    end else if (cmd_i.emit_tr) begin
      out_data_q.kind            <= KIND_TRAIN;
      out_data_q.winner          <= win_q;
      out_data_q.count_a_greater <= count_q;
      out_data_q.read_a          <= '0;
      out_data_q.read_b          <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.op       = op_q;
  assign status_o.last     = last_q;
  assign status_o.cnt_last = cnt_q == AW'(DIMENSIONS - 1);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ----- rtl/two_prototype_competitive_learner.sv -----
// Load item: capture and write. Read item: capture, prototype read, registered result.
// Train component without last: prototype read, square, accumulate. Items are taken only in idle.
// Closing component: accumulate and winner select; then the update reads, multiplies
// and writes back one component pair per pass through each memory's read and write port.
// Reset: rates take 6554 and 655, prototypes read as zero via per-entry valid bits,
// distances clear; no clearing pass, the block starts in idle with input ready.
`default_nettype none

module two_prototype_competitive_learner #(
  parameter int DIMENSIONS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  tpcl_pkg::cfg_reg_e          cfg_index_i,
  input  logic [tpcl_pkg::RATE_W-1:0] cfg_wdata_i,
  tpcl_in_if.sink                     in_i,
  tpcl_out_if.source                  out_o
);
  import tpcl_pkg::*;

  cmd_t    cmd;
  status_t status;

  tpcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tpcl_dpath #(
    .DIMENSIONS (DIMENSIONS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule

`default_nettype wire
